>>> rtl/twg_pkg.sv
// Shared types, constants and angle tables of the test waveform generator.
package twg_pkg;

  // Default parameter values
  localparam int CORDIC_STAGES_DEF = 18;
  localparam int LEVEL_WIDTH_DEF   = 32;

  // Field widths
  localparam int T_W     = 48;  // sample time, signed Q24.24
  localparam int LVL_W   = 32;  // configured levels, Q16.16
  localparam int FREQ_W  = 32;  // frequency, Q16.16
  localparam int CC_W    = 22;  // cycle count
  localparam int TIME_W  = 47;  // configured times, Q23.24
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 64;

  // Datapath widths
  localparam int CW        = 34;  // CORDIC x, y, z
  localparam int Q_W       = 33;  // decay argument, Q30
  localparam int DIV_STEPS = 33;  // quotient bits of the decay argument
  localparam int PROD_W    = 80;  // time times frequency
  localparam int BASE_W    = 55;  // initial plus amplitude times index
  localparam int DELTA_W   = 34;  // sine term
  localparam int TPROD_W   = 66;
  localparam int SUM_W     = 56;
  localparam int ALIGN_DLY = 32;  // sine term wait for the decay factor

  // Fixed-point constants
  localparam logic signed [CW-1:0] CIRC_START  = 34'sd652032874;
  localparam logic signed [CW-1:0] HYP_START   = 34'sd1296540104;
  localparam logic signed [CW-1:0] Q30_ONE     = 34'sd1073741824;
  localparam logic [30:0]          HALF_PI_Q30 = 31'd1686629713;
  localparam logic [Q_W-1:0]       LN2_X1      = 33'd744261118;
  localparam logic [Q_W-1:0]       LN2_X2      = 33'd1488522236;
  localparam logic [Q_W-1:0]       LN2_X4      = 33'd2977044472;

  typedef enum logic [1:0] {
    WAVE_STEPS  = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SINE   = 2'd2,
    WAVE_COSINE = 2'd3
  } wave_t;

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_DURING = 2'd1,
    PH_AFTER  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REG_WAVE_TYPE   = 3'd0,
    REG_INIT_LEVEL  = 3'd1,
    REG_AMPLITUDE   = 3'd2,
    REG_FREQUENCY   = 3'd3,
    REG_CYCLE_COUNT = 3'd4,
    REG_HALF_PERIOD = 3'd5,
    REG_DURATION    = 3'd6,
    REG_WINDOW_MODE = 3'd7
  } cfg_reg_t;

  localparam logic [1:0] WIN_NONE  = 2'd0;
  localparam logic [1:0] WIN_DECAY = 2'd2;

  // Side data that rides along the sine rotator
  typedef struct packed {
    phase_t          status;
    logic            trig;
    logic            inwin;
    logic [1:0]      quad;
    logic [CC_W-1:0] mult_idx;
  } meta_t;

  // Side data that waits for the decay factor
  typedef struct packed {
    phase_t                     status;
    logic                       add_delta;
    logic signed [BASE_W-1:0]   base;
    logic signed [DELTA_W-1:0]  delta;
  } tail_t;

  // Circular rotation angle atan(2^-i), Q30
  function automatic logic signed [CW-1:0] circ_angle(input int i);
    logic signed [CW-1:0] a;
    case (i)
      0:       a = 34'sd843314857;
      1:       a = 34'sd497837829;
      2:       a = 34'sd263043837;
      3:       a = 34'sd133525159;
      4:       a = 34'sd67021687;
      5:       a = 34'sd33543516;
      6:       a = 34'sd16775851;
      7:       a = 34'sd8388437;
      8:       a = 34'sd4194283;
      9:       a = 34'sd2097149;
      default: a = (i <= 30) ? CW'(64'sd1 <<< (30 - i)) : '0;
    endcase
    return a;
  endfunction

  // Hyperbolic shift of step n: steps four and thirteen run twice
  function automatic int hyp_index(input int n);
    return n + 1 - ((n >= 4) ? 1 : 0) - ((n >= 14) ? 1 : 0);
  endfunction

  // Hyperbolic rotation angle atanh(2^-i), Q30
  function automatic logic signed [CW-1:0] hyp_angle(input int i);
    logic signed [CW-1:0] a;
    case (i)
      1:       a = 34'sd589812981;
      2:       a = 34'sd274247418;
      3:       a = 34'sd134923406;
      4:       a = 34'sd67196451;
      5:       a = 34'sd33565361;
      6:       a = 34'sd16778582;
      7:       a = 34'sd8388779;
      8:       a = 34'sd4194325;
      9:       a = 34'sd2097155;
      10:      a = 34'sd1048576;
      default: a = (i <= 30) ? CW'(64'sd1 <<< (30 - i)) : '0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/twg_delay.sv
// Fixed-depth delay line carrying a valid bit with its data.
module twg_delay import twg_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             vld_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             vld_o,
  output logic [WIDTH-1:0] data_o
);

  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] data_r [0:DEPTH-1];

  // Shift valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = DEPTH - 1; k > 0; k--) begin
        vld_r[k] <= vld_r[k-1];
      end
      vld_r[0] <= vld_i;
    end
  end

  // Shift payload
  always_ff @(posedge clk) begin
    for (int k = DEPTH - 1; k > 0; k--) begin
      data_r[k] <= data_r[k-1];
    end
    data_r[0] <= data_i;
  end

  assign vld_o  = vld_r[DEPTH-1];
  assign data_o = data_r[DEPTH-1];

endmodule

>>> rtl/twg_divider.sv
// Pipelined restoring divider: 5 * t / duration as a Q30 fraction, one bit a stage.
module twg_divider import twg_pkg::*; (
  input  logic              clk,
  input  logic [TIME_W-1:0] t_i,
  input  logic [TIME_W-1:0] d_i,
  output logic [Q_W-1:0]    q_o
);

  logic [TIME_W+2:0] num;
  logic [TIME_W-1:0] rem_r [0:DIV_STEPS];
  logic [2:0]        dvb_r [0:DIV_STEPS];
  logic [Q_W-1:0]    q_r   [0:DIV_STEPS];

  // Scale the time by five and seed the remainder with its top bits
  assign num = ((TIME_W + 3)'(t_i) << 2) + (TIME_W + 3)'(t_i);

  always_ff @(posedge clk) begin
    rem_r[0] <= num[TIME_W+2:3];
    dvb_r[0] <= num[2:0];
    q_r[0]   <= '0;
  end

  // One quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [TIME_W:0] sh;
    logic [TIME_W:0] diff;
    logic            ge;

    assign sh   = {rem_r[j], dvb_r[j][2]};
    assign diff = sh - {1'b0, d_i};
    assign ge   = (sh >= {1'b0, d_i});

    always_ff @(posedge clk) begin
      rem_r[j+1] <= ge ? diff[TIME_W-1:0] : sh[TIME_W-1:0];
      dvb_r[j+1] <= dvb_r[j] << 1;
      q_r[j+1]   <= {q_r[j][Q_W-2:0], ge};
    end
  end

  assign q_o = q_r[DIV_STEPS];

endmodule

>>> rtl/twg_circ_cordic.sv
// Pipelined circular CORDIC rotator, one micro-rotation per stage.
module twg_circ_cordic import twg_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic [30:0]          z_i,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o
);

  logic signed [CW-1:0] x_r [0:STAGES-1];
  logic signed [CW-1:0] y_r [0:STAGES-1];
  logic signed [CW-1:0] z_r [0:STAGES-1];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic signed [CW-1:0] xi, yi, zi, xn, yn, zn;

    if (s == 0) begin : g_first
      assign xi = CIRC_START;
      assign yi = '0;
      assign zi = CW'(z_i);
    end else begin : g_next
      assign xi = x_r[s-1];
      assign yi = y_r[s-1];
      assign zi = z_r[s-1];
    end

    // Rotate toward zero residual angle
    always_comb begin
      if (!zi[CW-1]) begin
        xn = xi - (yi >>> s);
        yn = yi + (xi >>> s);
        zn = zi - circ_angle(s);
      end else begin
        xn = xi + (yi >>> s);
        yn = yi - (xi >>> s);
        zn = zi + circ_angle(s);
      end
    end

    always_ff @(posedge clk) begin
      x_r[s] <= xn;
      y_r[s] <= yn;
      z_r[s] <= zn;
    end
  end

  assign x_o = x_r[STAGES-1];
  assign y_o = y_r[STAGES-1];

endmodule

>>> rtl/twg_exp.sv
// Pipelined exp(-u): range reduction by ln2, hyperbolic CORDIC, final shift.
module twg_exp import twg_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                 clk,
  input  logic [Q_W-1:0]       u_i,
  output logic signed [CW-1:0] e_o
);

  logic [Q_W-1:0]       u1_r, u2_r, r_r;
  logic                 k2_r;
  logic [1:0]           k21_r;
  logic [2:0]           k_r;
  logic signed [CW-1:0] x_r [0:STAGES-1];
  logic signed [CW-1:0] y_r [0:STAGES-1];
  logic signed [CW-1:0] z_r [0:STAGES-1];
  logic [2:0]           kl_r [0:STAGES-1];
  logic signed [CW-1:0] e_r;

  // Reduce u by 4, 2 and 1 times ln2
  always_ff @(posedge clk) begin
    k2_r  <= (u_i >= LN2_X4);
    u1_r  <= (u_i >= LN2_X4) ? u_i - LN2_X4 : u_i;
    k21_r <= {k2_r, (u1_r >= LN2_X2)};
    u2_r  <= (u1_r >= LN2_X2) ? u1_r - LN2_X2 : u1_r;
    k_r   <= {k21_r, (u2_r >= LN2_X1)};
    r_r   <= (u2_r >= LN2_X1) ? u2_r - LN2_X1 : u2_r;
  end

  for (genvar n = 0; n < STAGES; n++) begin : g_stage
    localparam int SH = hyp_index(n);
    logic signed [CW-1:0] xi, yi, zi, xn, yn, zn;
    logic [2:0]           ki;

    if (n == 0) begin : g_first
      assign xi = HYP_START;
      assign yi = HYP_START;
      assign zi = CW'(0) - CW'(r_r);
      assign ki = k_r;
    end else begin : g_next
      assign xi = x_r[n-1];
      assign yi = y_r[n-1];
      assign zi = z_r[n-1];
      assign ki = kl_r[n-1];
    end

    // Hyperbolic micro-rotation
    always_comb begin
      if (!zi[CW-1]) begin
        xn = xi + (yi >>> SH);
        yn = yi + (xi >>> SH);
        zn = zi - hyp_angle(SH);
      end else begin
        xn = xi - (yi >>> SH);
        yn = yi - (xi >>> SH);
        zn = zi + hyp_angle(SH);
      end
    end

    always_ff @(posedge clk) begin
      x_r[n]  <= xn;
      y_r[n]  <= yn;
      z_r[n]  <= zn;
      kl_r[n] <= ki;
    end
  end

  // Scale by 2^-k
  always_ff @(posedge clk) begin
    e_r <= x_r[STAGES-1] >>> kl_r[STAGES-1];
  end

  assign e_o = e_r;

endmodule

>>> rtl/test_waveform_generator.sv
// Test waveform generator top level: front end, term math and output stage.
//
// Usage: write the eight configuration registers over cfg_* (cfg_ready is
// always high; an index above seven is ignored). Present a time stamp on
// in_sample_time with start high; busy is never raised, so one time stamp can
// be taken on every clock edge.
// Each time stamp yields exactly one beat on out_ref_value and
// out_phase_status, marked by out_valid for a single cycle. The path from a
// time stamp to out_valid is set by the 33-stage decay divider followed by
// the range reduction and hyperbolic CORDIC of the exponential; the sine
// path waits for it in a delay line.
// Throughput is one time stamp per cycle; results leave in input order.
// Reset clears all configuration registers to their documented defaults and
// drops every beat in flight. The receiver cannot stall, so no results are
// held back; configuration may only change while no beat is in flight.
module test_waveform_generator import twg_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int LEVEL_WIDTH   = LEVEL_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [T_W-1:0]         in_sample_time,
  output logic                          out_valid,
  output logic signed [LEVEL_WIDTH-1:0] out_ref_value,
  output logic [1:0]                    out_phase_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  localparam logic signed [SUM_W-1:0] LVL_MAX = SUM_W'((64'sd1 <<< (LEVEL_WIDTH - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] LVL_MIN = -LVL_MAX - SUM_W'(1);

  // Configuration registers
  wave_t                    wave_type_r;
  logic signed [LVL_W-1:0]  init_level_r;
  logic signed [LVL_W-1:0]  amplitude_r;
  logic [FREQ_W-1:0]        frequency_r;
  logic [CC_W-1:0]          cycle_count_r;
  logic [TIME_W-1:0]        half_period_r;
  logic [TIME_W-1:0]        duration_r;
  logic [1:0]               window_mode_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // Write configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_type_r   <= WAVE_STEPS;
      init_level_r  <= '0;
      amplitude_r   <= '0;
      frequency_r   <= FREQ_W'(65536);
      cycle_count_r <= CC_W'(1);
      half_period_r <= TIME_W'(8388608);
      duration_r    <= TIME_W'(16777216);
      window_mode_r <= WIN_NONE;
    end else if (cfg_valid && cfg_ready && (cfg_index[CFG_IDX_W-1:3] == '0)) begin
      case (cfg_reg_t'(cfg_index[2:0]))
        REG_WAVE_TYPE:   wave_type_r   <= wave_t'(cfg_wdata[1:0]);
        REG_INIT_LEVEL:  init_level_r  <= cfg_wdata[LVL_W-1:0];
        REG_AMPLITUDE:   amplitude_r   <= cfg_wdata[LVL_W-1:0];
        REG_FREQUENCY:   frequency_r   <= cfg_wdata[FREQ_W-1:0];
        REG_CYCLE_COUNT: cycle_count_r <= cfg_wdata[CC_W-1:0];
        REG_HALF_PERIOD: half_period_r <= cfg_wdata[TIME_W-1:0];
        REG_DURATION:    duration_r    <= cfg_wdata[TIME_W-1:0];
        REG_WINDOW_MODE: window_mode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Stage 1: capture time stamp
  logic                 v1_r;
  logic signed [T_W-1:0] t1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    t1_r <= in_sample_time;
  end

  // Stage 2: phase status, partial products, window distance
  logic              v2_r;
  phase_t            status2_r;
  logic [55:0]       plo2_r, phi2_r;
  logic              lthp2_r;
  logic [TIME_W-1:0] remt2_r;
  phase_t            status2_nxt;

  always_comb begin
    if (t1_r[T_W-1])                           status2_nxt = PH_BEFORE;
    else if (t1_r[TIME_W-1:0] >= duration_r)   status2_nxt = PH_AFTER;
    else                                       status2_nxt = PH_DURING;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    status2_r <= status2_nxt;
    plo2_r    <= 56'(t1_r[23:0]) * 56'(frequency_r);
    phi2_r    <= 56'(t1_r[47:24]) * 56'(frequency_r);
    lthp2_r   <= (t1_r[TIME_W-1:0] < half_period_r);
    remt2_r   <= duration_r - t1_r[TIME_W-1:0];
  end

  // Stage 3: full phase product and window zone
  logic              v3_r;
  phase_t            status3_r;
  logic [PROD_W-1:0] prod3_r;
  logic              inwin3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    status3_r <= status2_r;
    prod3_r   <= PROD_W'(plo2_r) + (PROD_W'(phi2_r) << 24);
    inwin3_r  <= lthp2_r || (remt2_r < half_period_r);
  end

  // Stage 4: step index, level multiplier, angle in radians
  logic            v4_r;
  meta_t           meta4_r;
  logic [60:0]     zprod4_r;
  logic [40:0]     q4;
  logic [CC_W-1:0] idx4, mult4;
  meta_t           meta4_nxt;

  always_comb begin
    q4   = (wave_type_r == WAVE_STEPS) ? {1'b0, prod3_r[79:40]} : prod3_r[79:39];
    idx4 = (q4 >= 41'(cycle_count_r)) ? cycle_count_r : q4[CC_W-1:0] + CC_W'(1);
    case (status3_r)
      PH_BEFORE: mult4 = '0;
      PH_AFTER:  mult4 = (wave_type_r == WAVE_STEPS) ? cycle_count_r : '0;
      default: begin
        case (wave_type_r)
          WAVE_STEPS:  mult4 = idx4;
          WAVE_SQUARE: mult4 = CC_W'(idx4[0]);
          default:     mult4 = '0;
        endcase
      end
    endcase
    meta4_nxt.status   = status3_r;
    meta4_nxt.trig     = (wave_type_r == WAVE_SINE) || (wave_type_r == WAVE_COSINE);
    meta4_nxt.inwin    = inwin3_r;
    meta4_nxt.quad     = prod3_r[39:38];
    meta4_nxt.mult_idx = mult4;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else        v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    meta4_r  <= meta4_nxt;
    zprod4_r <= 61'(prod3_r[37:8]) * 61'(HALF_PI_Q30);
  end

  // Sine and cosine of the first-quadrant angle
  logic signed [CW-1:0] cx, cy;

  twg_circ_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_circ (
    .clk (clk),
    .z_i (zprod4_r[60:30]),
    .x_o (cx),
    .y_o (cy)
  );

  // Hold side data across the rotator
  logic  va;
  meta_t meta_a;

  twg_delay #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (CORDIC_STAGES)
  ) u_dly_meta (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (v4_r),
    .data_i (meta4_r),
    .vld_o  (va),
    .data_o (meta_a)
  );

  // Stage 5: quadrant fold, term and level products, window factor
  logic signed [CW-1:0]      cos5, sin5, trig5, omc5, whalf5;
  logic [30:0]               w5;
  logic                      v5_r;
  meta_t                     meta5_r;
  logic signed [TPROD_W-1:0] tprod5_r;
  logic signed [BASE_W-1:0]  ampidx5_r;
  logic [30:0]               w5_r;

  always_comb begin
    case (meta_a.quad)
      2'd0:    begin cos5 = cx;  sin5 = cy;  end
      2'd1:    begin cos5 = -cy; sin5 = cx;  end
      2'd2:    begin cos5 = -cx; sin5 = -cy; end
      default: begin cos5 = cy;  sin5 = -cx; end
    endcase
    trig5  = (wave_type_r == WAVE_SINE) ? sin5 : cos5;
    omc5   = Q30_ONE - cos5;
    whalf5 = omc5 >>> 1;
    if (whalf5[CW-1])          w5 = '0;
    else if (whalf5 > Q30_ONE) w5 = 31'(Q30_ONE);
    else                       w5 = whalf5[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else        v5_r <= va;
  end

  always_ff @(posedge clk) begin
    meta5_r   <= meta_a;
    tprod5_r  <= TPROD_W'(amplitude_r) * TPROD_W'(trig5);
    ampidx5_r <= BASE_W'(amplitude_r) * BASE_W'($signed({1'b0, meta_a.mult_idx}));
    w5_r      <= w5;
  end

  // Stage 6: base level, raw term, windowed term product
  logic                      v6_r;
  meta_t                     meta6_r;
  logic signed [BASE_W-1:0]  base6_r;
  logic signed [DELTA_W-1:0] delta6_r;
  logic signed [TPROD_W-1:0] dw6_r;
  logic signed [DELTA_W-1:0] delta5;

  assign delta5 = tprod5_r[30+DELTA_W-1:30];

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else        v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    meta6_r  <= meta5_r;
    base6_r  <= BASE_W'(init_level_r) + ampidx5_r;
    delta6_r <= delta5;
    dw6_r    <= TPROD_W'(delta5) * TPROD_W'($signed({1'b0, w5_r}));
  end

  // Stage 7: pick windowed or plain term
  logic  v7_r;
  tail_t tail7_r;
  tail_t tail7_nxt;

  always_comb begin
    tail7_nxt.status    = meta6_r.status;
    tail7_nxt.add_delta = meta6_r.trig && (meta6_r.status == PH_DURING);
    tail7_nxt.base      = base6_r;
    if ((window_mode_r != WIN_NONE) && meta6_r.inwin) begin
      tail7_nxt.delta = dw6_r[30+DELTA_W-1:30];
    end else begin
      tail7_nxt.delta = delta6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else        v7_r <= v6_r;
  end

  always_ff @(posedge clk) begin
    tail7_r <= tail7_nxt;
  end

  // Decay argument and exponential, in parallel with the sine path
  logic [Q_W-1:0]       udec;
  logic signed [CW-1:0] edec;

  twg_divider u_div (
    .clk (clk),
    .t_i (t1_r[TIME_W-1:0]),
    .d_i (duration_r),
    .q_o (udec)
  );

  twg_exp #(
    .STAGES (CORDIC_STAGES)
  ) u_exp (
    .clk (clk),
    .u_i (udec),
    .e_o (edec)
  );

  // Wait for the decay factor
  logic  vb;
  tail_t tail_b;

  twg_delay #(
    .WIDTH ($bits(tail_t)),
    .DEPTH (ALIGN_DLY)
  ) u_dly_tail (
    .clk    (clk),
    .rst_n  (rst_n),
    .vld_i  (v7_r),
    .data_i (tail7_r),
    .vld_o  (vb),
    .data_o (tail_b)
  );

  // Stage 8: decayed term product
  logic                      v8_r;
  tail_t                     tail8_r;
  logic signed [TPROD_W+1:0] de8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v8_r <= 1'b0;
    else        v8_r <= vb;
  end

  always_ff @(posedge clk) begin
    tail8_r <= tail_b;
    de8_r   <= (TPROD_W + 2)'(tail_b.delta) * (TPROD_W + 2)'(edec);
  end

  // Stage 9: add term to base and saturate
  logic                          out_valid_r;
  logic signed [LEVEL_WIDTH-1:0] out_ref_r;
  logic [1:0]                    out_status_r;
  logic signed [DELTA_W-1:0]     dfin9;
  logic signed [SUM_W-1:0]       sum9, sat9;

  always_comb begin
    dfin9 = (window_mode_r >= WIN_DECAY) ? de8_r[30+DELTA_W-1:30] : tail8_r.delta;
    sum9  = SUM_W'(tail8_r.base) + (tail8_r.add_delta ? SUM_W'(dfin9) : '0);
    if (sum9 > LVL_MAX)      sat9 = LVL_MAX;
    else if (sum9 < LVL_MIN) sat9 = LVL_MIN;
    else                     sat9 = sum9;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= v8_r;
  end

  always_ff @(posedge clk) begin
    out_ref_r    <= sat9[LEVEL_WIDTH-1:0];
    out_status_r <= tail8_r.status;
  end

  assign out_valid        = out_valid_r;
  assign out_ref_value    = out_ref_r;
  assign out_phase_status = out_status_r;

endmodule

>>> bench/testbench.sv
// Self-checking bench for the test waveform generator: random and directed time stamps.
module testbench;
  import twg_pkg::*;

  localparam int            LEVEL_BITS    = 32;
  localparam int            WATCH_LIMIT   = 2000;
  localparam int            SETTLE_CYCLES = 64;
  localparam logic [7:0]    REG_UNUSED    = 8'd8;
  localparam logic [7:0]    REG_TOP       = 8'd255;
  localparam logic [1:0]    WIN_COSINE    = 2'd1;
  localparam logic [1:0]    WIN_DECAY_ALT = 2'd3;
  localparam longint        LN2_Q30_C     = 744261118;
  localparam longint        ONE_Q30       = 64'sd1 <<< 30;

  typedef struct {
    logic [LEVEL_BITS-1:0] level;
    logic [1:0]            status;
  } level_beat_t;

  // Scoreboard: register copy, level predictor and queue of expected beats
  class wave_scoreboard;
    logic [1:0]  wave;
    logic [31:0] init_r, amp_r, freq_r;
    logic [21:0] cycles_r;
    logic [46:0] half_r, dur_r;
    logic [1:0]  win_r;
    level_beat_t expected_levels[$];
    int          failures, checked, taken;
    longint      circ_tab[10];
    longint      hyp_tab[10];

    function new();
      circ_tab = '{843314857, 497837829, 263043837, 133525159, 67021687,
                   33543516, 16775851, 8388437, 4194283, 2097149};
      hyp_tab  = '{589812981, 274247418, 134923406, 67196451, 33565361,
                   16778582, 8388779, 4194325, 2097155, 1048576};
      wave = WAVE_STEPS; init_r = '0; amp_r = '0; freq_r = 32'd65536;
      cycles_r = 22'd1; half_r = 47'd8388608; dur_r = 47'd16777216; win_r = WIN_NONE;
    endfunction

    function void set_reg(logic [7:0] idx, logic [63:0] data);
      case (idx)
        REG_WAVE_TYPE:   wave     = data[1:0];
        REG_INIT_LEVEL:  init_r   = data[31:0];
        REG_AMPLITUDE:   amp_r    = data[31:0];
        REG_FREQUENCY:   freq_r   = data[31:0];
        REG_CYCLE_COUNT: cycles_r = data[21:0];
        REG_HALF_PERIOD: half_r   = data[46:0];
        REG_DURATION:    dur_r    = data[46:0];
        REG_WINDOW_MODE: win_r    = data[1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    // Circular rotation; returns cosine and sine in Q30 for a turn phase
    function void rotate(logic [31:0] ph, output longint c, output longint s);
      longint x, y, z, nx, ang;
      x = 652032874; y = 0;
      z = longint'((64'(ph[29:0]) * 64'd1686629713) >> 30);
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
        ang = (i < 10) ? circ_tab[i] : ((i <= 30) ? (64'sd1 <<< (30 - i)) : 0);
        if (z >= 0) begin
          nx = x - (y >>> i); y = y + (x >>> i); z -= ang;
        end else begin
          nx = x + (y >>> i); y = y - (x >>> i); z += ang;
        end
        x = nx;
      end
      case (ph[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
    endfunction

    // exp(-u) in Q30 by range reduction and hyperbolic rotation
    function longint decay_factor(longint u);
      longint k, x, y, z, nx, ang;
      int    i;
      bit    again;
      k = u / LN2_Q30_C;
      x = 1296540104; y = 1296540104;
      z = -(u - k * LN2_Q30_C);
      i = 1; again = 0;
      for (int n = 0; n < CORDIC_STAGES_DEF; n++) begin
        ang = (i <= 10) ? hyp_tab[i-1] : ((i <= 30) ? (64'sd1 <<< (30 - i)) : 0);
        if (z >= 0) begin
          nx = x + (y >>> i); y = y + (x >>> i); z -= ang;
        end else begin
          nx = x - (y >>> i); y = y - (x >>> i); z += ang;
        end
        x = nx;
        if ((i == 4 || i == 13) && !again) again = 1;
        else begin
          again = 0; i++;
        end
      end
      return x >>> k;
    endfunction

    // Note an accepted time stamp and queue the level it must produce
    function void note_input(logic signed [T_W-1:0] t_in);
      longint          t, init, amp, lvl, c, s, delta, w, u;
      longint unsigned ut, n, rem, q;
      logic [127:0]    prod, shifted;
      logic [1:0]      st;
      level_beat_t     beat;
      t = t_in; init = signed'(init_r); amp = signed'(amp_r);
      st = PH_DURING;
      ut = t;
      prod = 128'(ut) * 128'(freq_r);
      if (t < 0) begin
        lvl = init; st = PH_BEFORE;
      end else if (ut >= 64'(dur_r)) begin
        lvl = (wave == WAVE_STEPS) ? init + amp * longint'(cycles_r) : init;
        st = PH_AFTER;
      end else if (wave == WAVE_STEPS || wave == WAVE_SQUARE) begin
        shifted = prod >> ((wave == WAVE_STEPS) ? 40 : 39);
        q = (shifted[127:64] != 0) ? '1 : shifted[63:0];
        q = (q >= 64'(cycles_r)) ? 64'(cycles_r) : q + 1;
        if (wave == WAVE_STEPS) lvl = init + amp * longint'(q);
        else lvl = init + (q[0] ? amp : 0);
      end else begin
        rotate(prod[39:8], c, s);
        delta = (amp * ((wave == WAVE_SINE) ? s : c)) >>> 30;
        if (win_r != WIN_NONE) begin
          if (ut < 64'(half_r) || 64'(dur_r) - ut < 64'(half_r)) begin
            w = (ONE_Q30 - c) >>> 1;
            w = (w < 0) ? 0 : ((w > ONE_Q30) ? ONE_Q30 : w);
            delta = (delta * w) >>> 30;
          end
          if (win_r >= WIN_DECAY) begin
            n = 5 * ut;
            rem = n % 64'(dur_r);
            q = n / 64'(dur_r);
            for (int b = 0; b < 30; b++) begin
              rem = rem << 1; q = q << 1;
              if (rem >= 64'(dur_r)) begin
                rem -= 64'(dur_r); q = q | 1;
              end
            end
            u = q;
            delta = (delta * decay_factor(u)) >>> 30;
          end
        end
        lvl = init + delta;
      end
      if (lvl > 64'sd2147483647) lvl = 64'sd2147483647;
      if (lvl < -64'sd2147483648) lvl = -64'sd2147483648;
      beat.level = lvl[31:0];
      beat.status = st;
      expected_levels.push_back(beat);
      taken++;
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      failures++;
    endtask

    // Compare an output beat against the oldest expected level
    task check_result(logic [LEVEL_BITS-1:0] level, logic [1:0] status);
      level_beat_t want;
      checked++;
      if (expected_levels.size() == 0) begin
        report_mismatch($sformatf("unexpected beat level %h status %0d", level, status));
        return;
      end
      want = expected_levels.pop_front();
      if (level !== want.level)
        report_mismatch($sformatf("level %h, want %h", level, want.level));
      if (status !== want.status)
        report_mismatch($sformatf("status %0d, want %0d", status, want.status));
    endtask
  endclass

  logic                          clk, rst_n, start, busy;
  logic signed [T_W-1:0]         in_sample_time;
  logic                          out_valid;
  logic signed [LEVEL_BITS-1:0]  out_ref_value;
  logic [1:0]                    out_phase_status;
  logic                          cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index;
  logic [CFG_DATA_W-1:0]         cfg_wdata;

  wave_scoreboard sb = new();
  int idle_cycles = 0;
  int reg_writes = 0;
  int gap_pct = 0;

  test_waveform_generator DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_sample_time(in_sample_time), .out_valid(out_valid),
    .out_ref_value(out_ref_value), .out_phase_status(out_phase_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Monitor accepted beats and run the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) sb.note_input(in_sample_time);
      if (out_valid) sb.check_result(out_ref_value, out_phase_status);
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("watchdog expired with %0d beats outstanding", sb.pending());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task write_reg(logic [7:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    reg_writes++;
  endtask

  // Idle a random number of cycles, then hold the time stamp until taken
  task send_time(logic signed [T_W-1:0] t);
    while ($urandom_range(1, 100) <= gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_sample_time <= t;
    do @(posedge clk); while (busy);
  endtask

  task drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Pick a time stamp: mostly inside the function, some outside
  function logic signed [T_W-1:0] pick_time();
    int          r;
    logic [63:0] d, rv;
    r = $urandom_range(0, 99);
    d = 64'(sb.dur_r);
    rv = rand64();
    if (r < 8) return {1'b1, rv[46:0]};
    if (r < 16) return {1'b0, rv[46:0]} | 48'(d);
    if (r < 22) return rv[47:0];
    if (d == 0) return '0;
    if (r < 30) return 48'(64'(rv[46:0]) % (64'(sb.half_r) + 1)) % 48'(d);
    if (r < 38) return 48'(d - 1 - (64'(rv[46:0]) % d));
    return 48'(64'(rv[46:0]) % d);
  endfunction

  // Load a register set for one phase; first phases use the extremes
  task configure(int p);
    logic [63:0] dur, half;
    dur = (p == 2) ? 64'd0 : (p == 3) ? 64'h7FFF_FFFF_FFFF :
          ({$urandom_range(1, 12), 24'd0} + $urandom_range(0, 32'hFF_FFFF));
    half = (p == 4) ? 64'h7FFF_FFFF_FFFF : (p == 5) ? 64'd0 : dur / $urandom_range(2, 10);
    write_reg(REG_WAVE_TYPE, 64'(p % 4) | {$urandom, 30'd0});
    write_reg(REG_INIT_LEVEL, (p == 0) ? 64'h8000_0000 : (p == 1) ? 64'h7FFF_FFFF :
              64'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000));
    write_reg(REG_AMPLITUDE, (p == 0) ? 64'h7FFF_FFFF : (p == 1) ? 64'h8000_0000 :
              (p == 6) ? rand64() : 64'($signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000));
    write_reg(REG_FREQUENCY, (p == 4) ? 64'd0 : (p == 7) ? 64'hFFFF_FFFF :
              64'($urandom_range(32'h8000, 32'h0010_0000)));
    write_reg(REG_CYCLE_COUNT, (p == 5) ? 64'd0 : (p == 6) ? 64'h3F_FFFF :
              (p == 1) ? 64'd2097152 : 64'($urandom_range(1, 40)));
    write_reg(REG_HALF_PERIOD, half);
    write_reg(REG_DURATION, dur);
    write_reg(REG_WINDOW_MODE, 64'((p + p / 4) % 4));
    if (p % 5 == 0) write_reg((p == 0) ? REG_UNUSED : REG_TOP, rand64());
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n = 1'b0; start = 1'b0; in_sample_time = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_wdata = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, sine with window and decay at the edges, then cosine with decay and with window only
    send_time(48'sd0);
    send_time(-48'sd1);
    send_time({1'b1, 47'd0});
    send_time({1'b0, {47{1'b1}}});
    send_time(48'sd16777215);
    send_time(48'sd16777216);
    send_time(48'sd8388607);
    start <= 1'b0;
    drain();
    write_reg(REG_WAVE_TYPE, 64'(WAVE_SINE));
    write_reg(REG_AMPLITUDE, 64'h0001_0000);
    write_reg(REG_WINDOW_MODE, 64'(WIN_DECAY));
    write_reg(REG_FREQUENCY, 64'h0003_0000);
    cfg_valid <= 1'b0;
    for (int i = 0; i < 6; i++) send_time(48'(i * 48'sd3000000));
    start <= 1'b0;
    drain();
    write_reg(REG_WAVE_TYPE, 64'(WAVE_COSINE));
    write_reg(REG_WINDOW_MODE, 64'(WIN_DECAY_ALT));
    cfg_valid <= 1'b0;
    send_time(48'sd0);
    send_time(48'sd16777215);
    send_time(48'sd4194304);
    start <= 1'b0;
    drain();
    write_reg(REG_WINDOW_MODE, 64'(WIN_COSINE));
    cfg_valid <= 1'b0;
    send_time(48'sd0);
    send_time(48'sd12582912);
    send_time(48'sd16000000);
    start <= 1'b0;
    drain();

    // Random phases with rotating idle pressure
    for (int p = 0; p < 12; p++) begin
      configure(p);
      gap_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 80 : 10;
      for (int i = 0; i < 78; i++) begin
        if (p == 8 && i == 40) begin
          start <= 1'b0;
          while (sb.pending() != 0) @(posedge clk);
        end
        send_time(pick_time());
      end
      start <= 1'b0;
      drain();
    end

    $display("covered %0d time stamps over 12 register sets, %0d register writes",
             sb.taken, reg_writes);
    $display("checked %0d output beats across all four waveforms and window modes",
             sb.checked);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
